// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define TLSI_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition that must hold whenever the antecedent holds.
`define TLSI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tlsi_pkg.sv =====
package tlsi_pkg;

    // Internal step counter width; port field stays 16 bits
    localparam int STEP_BITS = 16;
    localparam int STEP_IN_W = 16;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request classes produced by the front
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CMD_A    = 2'd0;
    localparam kind_t KIND_CMD_B    = 2'd1;
    localparam kind_t KIND_CMD_NONE = 2'd2;
    localparam kind_t KIND_TICK     = 2'd3;

    // Motor codes on the input
    localparam logic [1:0] MOTOR_A = 2'd0;
    localparam logic [1:0] MOTOR_B = 2'd1;

    // Opcodes on the input
    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [STEP_BITS-1:0] step_t;
    typedef logic [STEP_BITS:0]   accum_t;

    typedef struct packed {
        kind_t kind;
        step_t steps;
        logic  dir;
        logic  last;
    } tlsi_item_t;

    typedef struct packed {
        logic step_a;
        logic step_b;
        logic dir_a;
        logic dir_b;
        logic enable_a;
        logic enable_b;
        logic busy;
        logic done;
        logic rejected;
    } tlsi_result_t;

endpackage

// ===== rtl/core/tlsi_front.sv =====
module tlsi_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [1:0]           motor,
    input  logic [15:0]          steps,
    input  logic                 direction,
    input  logic                 last,
    output logic                 push,
    output tlsi_pkg::tlsi_item_t item,
    input  logic                 q_full
);
    import tlsi_pkg::*;

    // Accept whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Classify the request for the back end
    always_comb
    begin
        item.steps = STEP_BITS'(steps);
        item.dir   = direction;
        item.last  = last;
        if (op == OP_TICK)
        begin
            item.kind = KIND_TICK;
        end
        else
        begin
            unique case (motor)
                MOTOR_A: item.kind = KIND_CMD_A;
                MOTOR_B: item.kind = KIND_CMD_B;
                default: item.kind = KIND_CMD_NONE;
            endcase
        end
    end

endmodule

// ===== rtl/core/tlsi_queue.sv =====
module tlsi_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tlsi_pkg::tlsi_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 q_valid,
    output tlsi_pkg::tlsi_item_t q_item,
    output logic [tlsi_pkg::QCNT_W-1:0] count
);
    import tlsi_pkg::*;

    tlsi_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign count   = cnt_reg;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/tlsi_back.sv =====
module tlsi_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  tlsi_pkg::tlsi_item_t   q_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output tlsi_pkg::tlsi_result_t result
);
    import tlsi_pkg::*;

    // Move state
    step_t  pend_a_reg, pend_a_next;
    step_t  pend_b_reg, pend_b_next;
    logic   pend_dir_a_reg, pend_dir_a_next;
    logic   pend_dir_b_reg, pend_dir_b_next;
    step_t  move_a_reg, move_a_next;
    step_t  move_b_reg, move_b_next;
    step_t  total_reg, total_next;
    accum_t acc_a_reg, acc_a_next;
    accum_t acc_b_reg, acc_b_next;
    step_t  cycles_reg, cycles_next;
    logic   busy_reg, busy_next;
    logic   en_a_reg, en_a_next;
    logic   en_b_reg, en_b_next;
    logic   dir_a_reg, dir_a_next;
    logic   dir_b_reg, dir_b_next;

    // Output register
    logic         out_valid_reg, out_valid_next;
    tlsi_result_t res_reg;
    tlsi_result_t res;

    // Scratch
    step_t  eff_a, eff_b, eff_total;
    logic   eff_dir_a, eff_dir_b;
    accum_t sum_a, sum_b;
    step_t  cyc_inc;

    // Take the next request when the output slot is free or draining
    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    // One DDA step per axis, then the command path
    always_comb
    begin
        pend_a_next     = pend_a_reg;
        pend_b_next     = pend_b_reg;
        pend_dir_a_next = pend_dir_a_reg;
        pend_dir_b_next = pend_dir_b_reg;
        move_a_next     = move_a_reg;
        move_b_next     = move_b_reg;
        total_next      = total_reg;
        acc_a_next      = acc_a_reg;
        acc_b_next      = acc_b_reg;
        cycles_next     = cycles_reg;
        busy_next       = busy_reg;
        en_a_next       = en_a_reg;
        en_b_next       = en_b_reg;
        dir_a_next      = dir_a_reg;
        dir_b_next      = dir_b_reg;

        res.step_a   = 1'b0;
        res.step_b   = 1'b0;
        res.done     = 1'b0;
        res.rejected = 1'b0;

        sum_a   = acc_a_reg + {1'b0, move_a_reg};
        sum_b   = acc_b_reg + {1'b0, move_b_reg};
        cyc_inc = cycles_reg + 1'b1;

        // Pending set with this entry applied
        eff_a     = (q_item.kind == KIND_CMD_A) ? q_item.steps : pend_a_reg;
        eff_b     = (q_item.kind == KIND_CMD_B) ? q_item.steps : pend_b_reg;
        eff_dir_a = (q_item.kind == KIND_CMD_A) ? q_item.dir : pend_dir_a_reg;
        eff_dir_b = (q_item.kind == KIND_CMD_B) ? q_item.dir : pend_dir_b_reg;
        eff_total = (eff_a > eff_b) ? eff_a : eff_b;

        priority if (q_item.kind == KIND_TICK)
        begin
            // Idle ticks change nothing
            if (busy_reg)
            begin
                if (sum_a >= {1'b0, total_reg})
                begin
                    res.step_a = 1'b1;
                    acc_a_next = sum_a - {1'b0, total_reg};
                end
                else
                begin
                    acc_a_next = sum_a;
                end
                if (sum_b >= {1'b0, total_reg})
                begin
                    res.step_b = 1'b1;
                    acc_b_next = sum_b - {1'b0, total_reg};
                end
                else
                begin
                    acc_b_next = sum_b;
                end
                cycles_next = cyc_inc;
                if (cyc_inc >= total_reg)
                begin
                    en_a_next = 1'b0;
                    en_b_next = 1'b0;
                    busy_next = 1'b0;
                    res.done  = 1'b1;
                end
            end
        end
        else if (busy_reg)
        begin
            res.rejected = 1'b1;
        end
        else
        begin
            pend_a_next     = eff_a;
            pend_b_next     = eff_b;
            pend_dir_a_next = eff_dir_a;
            pend_dir_b_next = eff_dir_b;
            if (q_item.last)
            begin
                move_a_next = eff_a;
                move_b_next = eff_b;
                total_next  = eff_total;
                if (eff_a != '0)
                begin
                    dir_a_next = eff_dir_a;
                    en_a_next  = 1'b1;
                end
                if (eff_b != '0)
                begin
                    dir_b_next = eff_dir_b;
                    en_b_next  = 1'b1;
                end
                acc_a_next  = '0;
                acc_b_next  = '0;
                cycles_next = '0;
                if (eff_total == '0)
                begin
                    res.done = 1'b1;
                end
                else
                begin
                    busy_next = 1'b1;
                end
                // Fresh pending set for the next move
                pend_a_next     = '0;
                pend_b_next     = '0;
                pend_dir_a_next = 1'b0;
                pend_dir_b_next = 1'b0;
            end
        end

        res.dir_a    = dir_a_next;
        res.dir_b    = dir_b_next;
        res.enable_a = en_a_next;
        res.enable_b = en_b_next;
        res.busy     = busy_next;

        out_valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // State registers advance only on a popped request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_a_reg     <= '0;
            pend_b_reg     <= '0;
            pend_dir_a_reg <= 1'b0;
            pend_dir_b_reg <= 1'b0;
            move_a_reg     <= '0;
            move_b_reg     <= '0;
            total_reg      <= '0;
            acc_a_reg      <= '0;
            acc_b_reg      <= '0;
            cycles_reg     <= '0;
            busy_reg       <= 1'b0;
            en_a_reg       <= 1'b0;
            en_b_reg       <= 1'b0;
            dir_a_reg      <= 1'b0;
            dir_b_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                pend_a_reg     <= pend_a_next;
                pend_b_reg     <= pend_b_next;
                pend_dir_a_reg <= pend_dir_a_next;
                pend_dir_b_reg <= pend_dir_b_next;
                move_a_reg     <= move_a_next;
                move_b_reg     <= move_b_next;
                total_reg      <= total_next;
                acc_a_reg      <= acc_a_next;
                acc_b_reg      <= acc_b_next;
                cycles_reg     <= cycles_next;
                busy_reg       <= busy_next;
                en_a_reg       <= en_a_next;
                en_b_reg       <= en_b_next;
                dir_a_reg      <= dir_a_next;
                dir_b_reg      <= dir_b_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== rtl/core/two_axis_linear_step_interpolator.sv =====
// Two-axis linear step interpolator. Command requests (op 0) collect a
// step count and direction per motor; the one flagged last starts a
// coordinated move, and each tick request (op 1) then runs one DDA step
// cycle, producing the step pulses of both axes for that cycle. Every
// request yields exactly one result. The block takes one request per
// clock while the queue has room and the output is not stalled: each tick
// costs one add, compare and subtract per axis in the back-end execution
// unit. A request is written into the two-entry request queue when it is
// accepted, and its result into the output register when the back end
// pops it from the queue. Commands sent during a move come back with
// rejected set and change nothing.
`include "assert_macros.svh"

module two_axis_linear_step_interpolator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [1:0]  motor,
    input  logic [15:0] steps,
    input  logic        direction,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        step_a,
    output logic        step_b,
    output logic        dir_a,
    output logic        dir_b,
    output logic        enable_a,
    output logic        enable_b,
    output logic        busy_res,
    output logic        move_done,
    output logic        rejected
);
    import tlsi_pkg::*;

    logic              push, q_full, q_valid, pop;
    tlsi_item_t        push_item, q_item;
    tlsi_result_t      result;
    logic [QCNT_W-1:0] q_count;

    // Front: accept and classify
    tlsi_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .motor     (motor),
        .steps     (steps),
        .direction (direction),
        .last      (last),
        .push      (push),
        .item      (push_item),
        .q_full    (q_full)
    );

    // Request queue
    tlsi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .count     (q_count)
    );

    // Back: move state and output register
    tlsi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign step_a    = result.step_a;
    assign step_b    = result.step_b;
    assign dir_a     = result.dir_a;
    assign dir_b     = result.dir_b;
    assign enable_a  = result.enable_a;
    assign enable_b  = result.enable_b;
    assign busy_res  = result.busy;
    assign move_done = result.done;
    assign rejected  = result.rejected;

    `TLSI_ASSERT(a_queue_bound, q_count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `TLSI_ASSERT_IMPL(a_busy_enabled, out_valid && busy_res, enable_a || enable_b,
        "busy move with no motor enabled")
    `TLSI_ASSERT_IMPL(a_done_idle, out_valid && move_done, !busy_res,
        "move done while still busy")
    `TLSI_ASSERT_IMPL(a_reject_quiet, out_valid && rejected,
        busy_res && !move_done && !step_a && !step_b, "rejected request had effect")

endmodule
